FILE: rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, codes and character helpers for the integer to ASCII
// formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int IN_DATA_W           = 64;
    localparam int DEFAULT_VALUE_WIDTH = 64;
    localparam int CHAR_W              = 8;
    localparam int LEN_W               = 5;
    localparam int OUT_DATA_W          = 16;

    localparam logic CMD_HEX = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic dec;
        logic neg;
    } item_ctrl_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {4'b0000, d};
        if (d >= 4'd10) begin
            return CHAR_ALPHA + dx - 8'd10;
        end
        return CHAR_ZERO + dx;
    endfunction

endpackage

FILE: rtl/itoa_front.sv
// ----------------------------------------------------------------------------
// itoa_front
// Accepts requests, masks the value, decodes the mode and forms the
// unsigned magnitude and sign for the back end.
// ----------------------------------------------------------------------------
module itoa_front
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic                   s_tuser,
    output logic                   q_valid,
    input  logic                   q_ready,
    output item_ctrl_t             q_ctrl,
    output logic [VALUE_WIDTH-1:0] q_mag
);

    logic                   valid_reg, valid_next;
    item_ctrl_t             ctrl_reg, ctrl_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [VALUE_WIDTH-1:0] raw;
    logic                   accept;

    assign s_tready = !valid_reg || q_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        raw            = s_tdata[VALUE_WIDTH-1:0];
        ctrl_next.dec  = (s_tuser == CMD_DEC);
        ctrl_next.neg  = ctrl_next.dec && raw[VALUE_WIDTH-1];
        mag_next       = ctrl_next.neg ? (~raw + VALUE_WIDTH'(1)) : raw;
        valid_next     = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ctrl_reg <= ctrl_next;
            mag_reg  <= mag_next;
        end
    end

    assign q_valid = valid_reg;
    assign q_ctrl  = ctrl_reg;
    assign q_mag   = mag_reg;

endmodule

FILE: rtl/itoa_queue.sv
// ----------------------------------------------------------------------------
// itoa_queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module itoa_queue
    import itoa_pkg::*;
#(
    parameter int DATA_W = DEFAULT_VALUE_WIDTH + 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: rtl/itoa_back.sv
// ----------------------------------------------------------------------------
// itoa_back
// Converts one magnitude to digits (shift-and-add-3 for decimal, nibble
// load for hex), skips leading zeros and emits the characters.
// ----------------------------------------------------------------------------
module itoa_back
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  item_ctrl_t             q_ctrl,
    input  logic [VALUE_WIDTH-1:0] q_mag,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [CHAR_W-1:0]      m_char,
    output logic                   m_last,
    output logic [LEN_W-1:0]       m_len
);

    localparam int DEC_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int DIGITS     = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int PTR_W      = $clog2(DIGITS);
    localparam int CNT_W      = $clog2(VALUE_WIDTH);
    localparam int HEX_EXT_W  = 4 * DIGITS;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [3:0]             digits_reg [DIGITS];
    logic [3:0]             digits_next [DIGITS];
    logic [3:0]             adj [DIGITS];
    logic [VALUE_WIDTH-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [PTR_W-1:0]       ptr_reg, ptr_next;
    logic                   neg_reg, neg_next;
    logic                   sign_pend_reg, sign_pend_next;
    logic [LEN_W-1:0]       total_reg, total_next;
    logic                   m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]      m_char_reg, m_char_next;
    logic                   m_last_reg, m_last_next;
    logic [LEN_W-1:0]       m_len_reg, m_len_next;
    logic [HEX_EXT_W-1:0]   hex_ext;
    logic                   out_free;
    logic                   is_last;

    assign q_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign hex_ext  = HEX_EXT_W'(q_mag);

    always_comb begin
        state_next     = state_reg;
        digits_next    = digits_reg;
        shift_next     = shift_reg;
        bit_cnt_next   = bit_cnt_reg;
        ptr_next       = ptr_reg;
        neg_next       = neg_reg;
        sign_pend_next = sign_pend_reg;
        total_next     = total_reg;
        m_valid_next   = m_valid_reg;
        m_char_next    = m_char_reg;
        m_last_next    = m_last_reg;
        m_len_next     = m_len_reg;
        is_last        = 1'b0;

        for (int i = 0; i < DIGITS; i++) begin
            adj[i] = (digits_reg[i] >= 4'd5) ? digits_reg[i] + 4'd3 : digits_reg[i];
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    neg_next       = q_ctrl.neg;
                    sign_pend_next = q_ctrl.neg;
                    if (q_ctrl.dec) begin
                        shift_next   = q_mag;
                        bit_cnt_next = '0;
                        for (int i = 0; i < DIGITS; i++) begin
                            digits_next[i] = 4'd0;
                        end
                        state_next = ST_CONV;
                    end else begin
                        for (int i = 0; i < DIGITS; i++) begin
                            digits_next[i] = hex_ext[4*i +: 4];
                        end
                        ptr_next   = PTR_W'(HEX_DIGITS - 1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_CONV: begin
                digits_next[0] = {adj[0][2:0], shift_reg[VALUE_WIDTH-1]};
                for (int i = 1; i < DIGITS; i++) begin
                    digits_next[i] = {adj[i][2:0], adj[i-1][3]};
                end
                shift_next   = shift_reg << 1;
                bit_cnt_next = bit_cnt_reg + CNT_W'(1);
                if (bit_cnt_reg == CNT_W'(VALUE_WIDTH - 1)) begin
                    ptr_next   = PTR_W'(DEC_DIGITS - 1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if ((digits_reg[ptr_reg] == 4'd0) && (ptr_reg != '0)) begin
                    ptr_next = ptr_reg - PTR_W'(1);
                end else begin
                    total_next = LEN_W'(neg_reg) + LEN_W'(ptr_reg) + LEN_W'(1);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (sign_pend_reg) begin
                        sign_pend_next = 1'b0;
                        m_char_next    = CHAR_MINUS;
                    end else begin
                        m_char_next = digit_char(digits_reg[ptr_reg]);
                        is_last     = (ptr_reg == '0);
                        if (is_last) begin
                            state_next = ST_IDLE;
                        end else begin
                            ptr_next = ptr_reg - PTR_W'(1);
                        end
                    end
                    m_last_next = is_last;
                    m_len_next  = is_last ? total_reg : '0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            sign_pend_reg <= 1'b0;
            neg_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            sign_pend_reg <= sign_pend_next;
            neg_reg       <= neg_next;
        end
    end

    always_ff @(posedge aclk) begin
        digits_reg  <= digits_next;
        shift_reg   <= shift_next;
        bit_cnt_reg <= bit_cnt_next;
        ptr_reg     <= ptr_next;
        total_reg   <= total_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
        m_len_reg   <= m_len_next;
    end

    assign m_valid = m_valid_reg;
    assign m_char  = m_char_reg;
    assign m_last  = m_last_reg;
    assign m_len   = m_len_reg;

endmodule

FILE: rtl/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats a value as uppercase hex or signed decimal ASCII, one character
// per output transfer, most significant first.
// ----------------------------------------------------------------------------
// A request passes the front register and the queue; the back end then
// loads the hex nibbles, or runs shift-and-add-3 over all VALUE_WIDTH bits
// in decimal, scans off leading zeros (up to 16 hex or 20 decimal digits at
// the default width) and puts each character in the output register once free.
// The back end takes a new request only when idle, after its last character
// is registered; up to 3 more requests wait in the front register and the queue.
// Reset: synchronous active-low aresetn empties the front register, the queue,
// the back-end state machine and the output register.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [63:0] value
    input  logic                  s_tuser,   // [0] cmd
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] character, [12:8] length
    output logic                  m_tlast
);

    localparam int ITEM_W = VALUE_WIDTH + $bits(item_ctrl_t);

    logic                   f_valid, f_ready;
    item_ctrl_t             f_ctrl, b_ctrl;
    logic [VALUE_WIDTH-1:0] f_mag, b_mag;
    logic                   b_valid, b_ready;
    logic [ITEM_W-1:0]      b_data;
    logic [CHAR_W-1:0]      m_char;
    logic [LEN_W-1:0]       m_len;

    itoa_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .q_valid (f_valid),
        .q_ready (f_ready),
        .q_ctrl  (f_ctrl),
        .q_mag   (f_mag)
    );

    itoa_queue #(
        .DATA_W(ITEM_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_data  ({f_ctrl, f_mag}),
        .out_valid(b_valid),
        .out_ready(b_ready),
        .out_data (b_data)
    );

    assign b_ctrl = b_data[ITEM_W-1:VALUE_WIDTH];
    assign b_mag  = b_data[VALUE_WIDTH-1:0];

    itoa_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (b_valid),
        .q_ready (b_ready),
        .q_ctrl  (b_ctrl),
        .q_mag   (b_mag),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_char  (m_char),
        .m_last  (m_tlast),
        .m_len   (m_len)
    );

    assign m_tdata = {(OUT_DATA_W - CHAR_W - LEN_W)'(0), m_len, m_char};

    a_len_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_len != '0))
        else $error("length missing on last character");

    a_len_zero_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_len == '0))
        else $error("length set on a non-final character");

    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_char == CHAR_MINUS)) |-> !m_tlast)
        else $error("sign emitted as final character");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output changed while stalled");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives integer_to_ascii_formatter_core with hex and signed decimal requests
// and compares every emitted character, its last flag and the length field
// against a local formatter model, with random idle gaps on both streams.
// ----------------------------------------------------------------------------
module testbench;
    import itoa_pkg::*;

    localparam int WIDTH       = DEFAULT_VALUE_WIDTH;
    localparam int MAX_TEXT    = 20;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 150;
    localparam int REPORT_MAX  = 10;
    localparam int RANDOM_REQS = 87;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic [LEN_W-1:0]  len;
    } text_char_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = CMD_HEX;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    text_char_t expected_text[$];
    int         error_count = 0;
    int         idle_cycles = 0;
    int         stall_left  = 0;
    bit         steady_run  = 1'b0;

    integer_to_ascii_formatter_core #(
        .VALUE_WIDTH(WIDTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CHAR_W-1:0] glyph_for(input logic [3:0] nibble);
        if (nibble < 4'd10) begin
            return CHAR_ZERO + {4'b0000, nibble};
        end
        return CHAR_ALPHA + {4'b0000, nibble - 4'd10};
    endfunction

    function automatic void predict_text(input logic cmd, input logic [IN_DATA_W-1:0] value);
        logic [IN_DATA_W-1:0] mask;
        logic [IN_DATA_W-1:0] magnitude;
        logic [IN_DATA_W-1:0] radix;
        logic [3:0]           digits[MAX_TEXT];
        logic                 negative;
        int                   count;
        int                   total;
        int                   emitted;
        text_char_t           item;
        mask      = {IN_DATA_W{1'b1}} >> (IN_DATA_W - WIDTH);
        magnitude = value & mask;
        negative  = (cmd == CMD_DEC) && magnitude[WIDTH-1];
        if (negative) begin
            magnitude = (~magnitude + 1'b1) & mask;
        end
        radix = (cmd == CMD_DEC) ? 64'd10 : 64'd16;
        count = 0;
        if (magnitude == 0) begin
            digits[0] = 4'd0;
            count     = 1;
        end else begin
            while (magnitude != 0 && count < MAX_TEXT) begin
                digits[count] = 4'(magnitude % radix);
                magnitude     = magnitude / radix;
                count++;
            end
        end
        total   = count + (negative ? 1 : 0);
        emitted = 0;
        if (negative) begin
            emitted++;
            item.ch   = CHAR_MINUS;
            item.last = (emitted == total);
            item.len  = item.last ? LEN_W'(total) : '0;
            expected_text.push_back(item);
        end
        for (int i = count - 1; i >= 0; i--) begin
            emitted++;
            item.ch   = glyph_for(digits[i]);
            item.last = (emitted == total);
            item.len  = item.last ? LEN_W'(total) : '0;
            expected_text.push_back(item);
        end
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_value();
        logic [IN_DATA_W-1:0] v;
        logic [IN_DATA_W-1:0] p;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            2: begin
                v = {$urandom, $urandom} >> $urandom_range(1, 63);
                v = ~v + 1'b1;
            end
            3: begin
                p = 64'd1;
                repeat ($urandom_range(0, 19)) p = p * 64'd10;
                v = p + 64'($urandom_range(0, 2)) - 64'd1;
                if ($urandom_range(0, 1) == 1) begin
                    v = ~v + 1'b1;
                end
            end
            4: begin
                case ($urandom_range(0, 3))
                    0: v = '0;
                    1: v = 64'd1;
                    2: v = '1;
                    default: v = {1'b1, 63'd0};
                endcase
            end
            default: v = 64'd1 << $urandom_range(0, 63);
        endcase
        return v;
    endfunction

    task automatic send_request(input logic cmd, input logic [IN_DATA_W-1:0] value);
        int gap;
        bit taken;
        gap = steady_run ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= value;
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        predict_text(cmd, value);
    endtask

    task automatic test_zero_and_extremes();
        steady_run = 1'b1;
        send_request(CMD_HEX, '0);
        send_request(CMD_DEC, '0);
        send_request(CMD_HEX, '1);
        send_request(CMD_DEC, '1);
        steady_run = 1'b0;
        send_request(CMD_DEC, {1'b1, 63'd0});
        send_request(CMD_DEC, {1'b0, {63{1'b1}}});
        send_request(CMD_HEX, {1'b1, 63'd0});
        send_request(CMD_HEX, 64'd1);
        send_request(CMD_DEC, 64'd1);
    endtask

    task automatic test_digit_set();
        send_request(CMD_HEX, 64'h0123_4567_89AB_CDEF);
        send_request(CMD_HEX, 64'hFEDC_BA98_7654_3210);
        send_request(CMD_DEC, 64'd1234567890);
        send_request(CMD_DEC, 64'd9876543210);
        send_request(CMD_HEX, 64'hF);
        send_request(CMD_HEX, 64'h10);
        send_request(CMD_DEC, 64'd9);
        send_request(CMD_DEC, 64'd10);
    endtask

    task automatic test_sign_handling();
        send_request(CMD_DEC, 64'hFFFF_FFFF_FFFF_FFF6);
        send_request(CMD_DEC, 64'hFFFF_FFFF_FFFF_FFF7);
        send_request(CMD_DEC, {1'b1, 62'd0, 1'b1});
        send_request(CMD_DEC, ~64'd1000000000000000000 + 64'd1);
        send_request(CMD_DEC, 64'd1000000000000000000);
        send_request(CMD_HEX, 64'hFFFF_FFFF_FFFF_FFF6);
    endtask

    task automatic test_random_values();
        for (int i = 0; i < RANDOM_REQS; i++) begin
            steady_run = ((i / 20) % 3 == 1);
            send_request(logic'($urandom_range(0, 1)), random_value());
        end
        steady_run = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (!steady_run && $urandom_range(0, 2) == 0) begin
                stall_left <= pick_gap();
            end
        end
    end

    always @(negedge aclk) begin : result_check
        text_char_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (m_tvalid && m_tready) begin
                if (expected_text.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_MAX) begin
                        $display("unexpected character %h last %b length %0d",
                                 m_tdata[7:0], m_tlast, m_tdata[12:8]);
                    end
                end else begin
                    want = expected_text.pop_front();
                    if (m_tdata[7:0] !== want.ch || m_tlast !== want.last ||
                        m_tdata[12:8] !== want.len) begin
                        error_count++;
                        if (error_count <= REPORT_MAX) begin
                            $display(
                                "mismatch: expected char %h last %b length %0d, got %h %b %0d",
                                want.ch, want.last, want.len,
                                m_tdata[7:0], m_tlast, m_tdata[12:8]);
                        end
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_zero_and_extremes();
        test_digit_set();
        test_sign_handling();
        test_random_values();
        s_tvalid <= 1'b0;
        while (expected_text.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0 && expected_text.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/itoa_pkg.sv
rtl/itoa_front.sv
rtl/itoa_queue.sv
rtl/itoa_back.sv
rtl/integer_to_ascii_formatter_core.sv
tb/testbench.sv
